// ----- hdl/assert_macros.svh -----
// assertion macros shared by the deque engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- hdl/mqde_pkg.sv -----
// shared codes, field layout and types of the multi-queue deque engine
package mqde_pkg;

  // request kinds (code 3 is treated as a query)
  localparam int KIND_W = 2;
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_ADD   = 2'd0;
  localparam kind_t KIND_TAKE  = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;

  // result status codes
  localparam int STATUS_W = 2;
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  // stream widths
  localparam int DATA_W = 24;
  localparam int USER_W = 2;

  // request tdata layout
  localparam int QID_W    = 4;
  localparam int QID_LSB  = 0;
  localparam int TAG_IN_W = 16;
  localparam int TAG_LSB  = 4;
  localparam int URG_BIT  = 20;

  // result tdata layout
  localparam int OTAG_LSB = 0;
  localparam int OURG_BIT = 16;
  localparam int HAS_BIT  = 17;

endpackage

// ----- hdl/mqde_entry_mem.sv -----
// single-port entry storage, one registered read per cycle
module mqde_entry_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 17
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/mqde_ptr_mem.sv -----
// per-queue head and count memory with valid bits standing in for the zero reset
`include "assert_macros.svh"

module mqde_ptr_mem #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 64,
  localparam int QidxW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int HeadW = $clog2(QUEUE_DEPTH),
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [QidxW-1:0] rd_addr_i,
  output logic [HeadW-1:0] rd_head_o,
  output logic [CntW-1:0]  rd_cnt_o,
  input  logic             wr_en_i,
  input  logic [QidxW-1:0] wr_addr_i,
  input  logic [HeadW-1:0] wr_head_i,
  input  logic [CntW-1:0]  wr_cnt_i
);

  logic [HeadW+CntW-1:0] mem_q [NUM_QUEUES];
  logic [HeadW+CntW-1:0] rd_data_q;
  logic [NUM_QUEUES-1:0] vld_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_head_i, wr_cnt_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // an untouched queue reads as head zero, count zero
  assign rd_head_o = rd_vld_q ? rd_data_q[CntW +: HeadW] : '0;
  assign rd_cnt_o  = rd_vld_q ? rd_data_q[CntW-1:0] : '0;

  `ASSERT_CLK(a_cnt_in_range, wr_en_i |-> (wr_cnt_i <= CntW'(QUEUE_DEPTH)), "count above depth")
  `ASSERT_CLK(a_head_in_range, wr_en_i |-> (wr_head_i < HeadW'(QUEUE_DEPTH - 1) || wr_head_i == HeadW'(QUEUE_DEPTH - 1)), "head outside ring")
  `ASSERT_NEVER(a_wr_addr_range, wr_en_i && (32'(wr_addr_i) >= 32'(NUM_QUEUES)), "write to missing queue")

endmodule

// ----- hdl/multi_queue_deque_engine_top.sv -----
// Multi-queue deque engine: NUM_QUEUES deques of QUEUE_DEPTH entries, each entry a tag and an
// urgent flag. An add appends a normal entry at the tail or pushes an urgent one at the head, a
// take pops the head, a query reports whether the queue holds anything; every request gives
// exactly one result. Each request first reads the queue's head and count from the pointer
// memory, then updates them, writes them back and writes or reads the entry memory; the result
// then sits in the output register, and the next request is taken in that same cycle as long as
// the result register can be loaded, so a new request is never taken before the last one's
// result is loaded. A taken entry's data comes straight from the entry memory's read register.
// Queue state is valid right after reset with no clearing pass. An id at or above NUM_QUEUES
// addresses no queue: an add answers full, a take answers empty, has_entries is zero. Kind code
// 3 acts as a query.
`include "assert_macros.svh"

module multi_queue_deque_engine_top #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_WIDTH   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // queue_id [3:0], tag [19:4], urgent [20], zero [23:21]
  input  logic [mqde_pkg::DATA_W-1:0] s_axis_tdata,
  // kind [1:0]
  input  logic [mqde_pkg::USER_W-1:0] s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_tag [15:0], out_urgent [16], has_entries [17], zero [23:18]
  output logic [mqde_pkg::DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [mqde_pkg::USER_W-1:0] m_axis_tuser
);

  localparam int QidxW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int HeadW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW  = CntW + 1;
  localparam int TagW  = (TAG_WIDTH < mqde_pkg::TAG_IN_W) ? TAG_WIDTH : mqde_pkg::TAG_IN_W;
  localparam int EntW  = TagW + 1;
  localparam int EntDepth = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AddrW = $clog2(EntDepth);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PTR  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  // request fields
  logic [mqde_pkg::QID_W-1:0] in_qid;
  logic                       in_ok;
  logic                       accept;

  mqde_pkg::kind_t req_kind_q;
  logic [QidxW-1:0] req_qid_q;
  logic             req_ok_q;
  logic [TagW-1:0]  req_tag_q;
  logic             req_urg_q;

  // pointer memory
  logic [HeadW-1:0] head;
  logic [CntW-1:0]  cnt;
  logic             ptr_wr_en;
  logic [HeadW-1:0] wr_head;
  logic [CntW-1:0]  wr_cnt;

  // entry memory
  logic             ent_wr_en;
  logic             ent_rd_en;
  logic [HeadW-1:0] ent_pos;
  logic [AddrW-1:0] ent_addr;
  logic [EntW-1:0]  ent_rd_data;

  // ring arithmetic
  logic             cnt_nz;
  logic             full;
  logic [SumW-1:0]  tail_sum;
  logic [HeadW-1:0] tail_pos;
  logic [HeadW-1:0] head_dec;
  logic [HeadW-1:0] head_inc;

  // pending result
  mqde_pkg::status_t res_status_q, res_status_d;
  logic             res_has_q, res_has_d;
  logic             res_take_q, res_take_d;

  // output register
  logic                        m_valid_q, m_valid_d;
  logic [mqde_pkg::DATA_W-1:0] m_data_q, m_data_d;
  mqde_pkg::status_t           m_user_q;
  logic                        out_free;
  logic                        out_load;

  assign in_qid = s_axis_tdata[mqde_pkg::QID_LSB +: mqde_pkg::QID_W];
  assign in_ok  = 32'(in_qid) < 32'(NUM_QUEUES);

  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = (state_q == ST_DONE) && out_free;
  assign s_axis_tready = (state_q == ST_IDLE) || out_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_kind_q <= s_axis_tuser;
      req_qid_q  <= QidxW'(in_qid);
      req_ok_q   <= in_ok;
      req_tag_q  <= s_axis_tdata[mqde_pkg::TAG_LSB +: TagW];
      req_urg_q  <= s_axis_tdata[mqde_pkg::URG_BIT];
    end
  end

  mqde_ptr_mem #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ptr_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_ok),
    .rd_addr_i (QidxW'(in_qid)),
    .rd_head_o (head),
    .rd_cnt_o  (cnt),
    .wr_en_i   (ptr_wr_en),
    .wr_addr_i (req_qid_q),
    .wr_head_i (wr_head),
    .wr_cnt_i  (wr_cnt)
  );

  assign cnt_nz   = cnt != '0;
  assign full     = cnt == CntW'(QUEUE_DEPTH);
  assign tail_sum = SumW'(head) + SumW'(cnt);
  assign tail_pos = (tail_sum >= SumW'(QUEUE_DEPTH)) ? HeadW'(tail_sum - SumW'(QUEUE_DEPTH))
                                                     : HeadW'(tail_sum);
  assign head_dec = (head == '0) ? HeadW'(QUEUE_DEPTH - 1) : head - HeadW'(1);
  assign head_inc = (head == HeadW'(QUEUE_DEPTH - 1)) ? '0 : head + HeadW'(1);

  // queue base plus ring position
  assign ent_addr = AddrW'(req_qid_q) * AddrW'(QUEUE_DEPTH) + AddrW'(ent_pos);

  always_comb begin
    ptr_wr_en    = 1'b0;
    wr_head      = head;
    wr_cnt       = cnt;
    ent_wr_en    = 1'b0;
    ent_rd_en    = 1'b0;
    ent_pos      = head;
    res_status_d = res_status_q;
    res_has_d    = res_has_q;
    res_take_d   = res_take_q;
    if (state_q == ST_PTR) begin
      res_status_d = mqde_pkg::STATUS_OK;
      res_has_d    = req_ok_q && cnt_nz;
      res_take_d   = 1'b0;
      case (req_kind_q)
        mqde_pkg::KIND_ADD: begin
          if (!req_ok_q || full) begin
            res_status_d = mqde_pkg::STATUS_FULL;
          end else begin
            ptr_wr_en = 1'b1;
            ent_wr_en = 1'b1;
            ent_pos   = req_urg_q ? head_dec : tail_pos;
            wr_head   = req_urg_q ? head_dec : head;
            wr_cnt    = cnt + CntW'(1);
            res_has_d = 1'b1;
          end
        end
        mqde_pkg::KIND_TAKE: begin
          if (!req_ok_q || !cnt_nz) begin
            res_status_d = mqde_pkg::STATUS_EMPTY;
            res_has_d    = 1'b0;
          end else begin
            ptr_wr_en  = 1'b1;
            ent_rd_en  = 1'b1;
            wr_head    = head_inc;
            wr_cnt     = cnt - CntW'(1);
            res_has_d  = cnt != CntW'(1);
            res_take_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  mqde_entry_mem #(
    .DEPTH (EntDepth),
    .WIDTH (EntW)
  ) u_entry_mem (
    .clk_i     (clk_i),
    .wr_en_i   (ent_wr_en),
    .rd_en_i   (ent_rd_en),
    .addr_i    (ent_addr),
    .wr_data_i ({req_urg_q, req_tag_q}),
    .rd_data_o (ent_rd_data)
  );

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_has_q    <= res_has_d;
    res_take_q   <= res_take_d;
  end

  always_comb begin
    m_data_d = '0;
    if (res_take_q) begin
      m_data_d[mqde_pkg::OTAG_LSB +: mqde_pkg::TAG_IN_W] =
        mqde_pkg::TAG_IN_W'(ent_rd_data[TagW-1:0]);
      m_data_d[mqde_pkg::OURG_BIT] = ent_rd_data[TagW];
    end
    m_data_d[mqde_pkg::HAS_BIT] = res_has_q;
  end

  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
      m_user_q <= res_status_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PTR;
        end
      end
      ST_PTR: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = accept ? ST_PTR : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `ASSERT_CLK(a_accept_starts, (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_PTR), "request accepted but lookup not started")
  `ASSERT_CLK(a_ptr_wr_in_ptr, ptr_wr_en |-> (state_q == ST_PTR), "pointer write outside update cycle")
  `ASSERT_NEVER(a_ent_rd_wr, ent_wr_en && ent_rd_en, "entry read and write in one cycle")
  `ASSERT_CLK(a_done_holds, (state_q == ST_DONE && !out_free) |=> (state_q == ST_DONE && m_axis_tvalid), "pending result lost while output stalled")

endmodule

// ----- bench/multi_queue_deque_engine_top_tb.sv -----
// self-checking stream testbench for the multi-queue deque engine
`timescale 1ns / 1ps

module multi_queue_deque_engine_top_tb;

  localparam int NUM_Q       = 16;
  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 18;
  localparam int RANDOM_REQS = 600;
  localparam mqde_pkg::kind_t KIND_SPARE = 2'd3;

  typedef struct packed {
    mqde_pkg::kind_t kind;
    logic [3:0]      qid;
    logic [15:0]     tag;
    logic            urgent;
    logic            hold;
  } request_t;

  typedef struct packed {
    mqde_pkg::status_t status;
    logic [15:0]       out_tag;
    logic              out_urgent;
    logic              has_entries;
  } response_t;

  typedef struct packed {
    logic [15:0] tag;
    logic        urgent;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mqde_pkg::DATA_W-1:0] s_axis_tdata = '0;
  logic [mqde_pkg::USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mqde_pkg::DATA_W-1:0] m_axis_tdata;
  logic [mqde_pkg::USER_W-1:0] m_axis_tuser;

  request_t  request_q[$];
  response_t predicted_resp_q[$];
  entry_t    deque_model[NUM_Q][$];
  int        sent_n = 0;
  int        outstanding = 0;
  int        errors = 0;
  int        cycle_n = 0;
  logic      calm;

  multi_queue_deque_engine_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // no idling on either side while this window of requests goes out
  assign calm = (sent_n >= 250) && (sent_n < 400);

  // applies one request to the deque model and returns the response it gives
  function automatic response_t deque_apply(request_t r);
    response_t resp;
    entry_t    e;
    resp = '0;
    resp.status = mqde_pkg::STATUS_OK;
    if (r.kind == mqde_pkg::KIND_ADD) begin
      if (deque_model[r.qid].size() >= DEPTH) begin
        resp.status = mqde_pkg::STATUS_FULL;
      end else begin
        e.tag = r.tag;
        e.urgent = r.urgent;
        if (r.urgent) deque_model[r.qid].insert(0, e);
        else deque_model[r.qid].insert(deque_model[r.qid].size(), e);
      end
    end else if (r.kind == mqde_pkg::KIND_TAKE) begin
      if (deque_model[r.qid].size() == 0) begin
        resp.status = mqde_pkg::STATUS_EMPTY;
      end else begin
        e = deque_model[r.qid][0];
        deque_model[r.qid].delete(0);
        resp.out_tag = e.tag;
        resp.out_urgent = e.urgent;
      end
    end
    resp.has_entries = deque_model[r.qid].size() > 0;
    return resp;
  endfunction

  task automatic push_req(mqde_pkg::kind_t kind, int qid, int tag, bit urgent,
                          bit hold = 1'b0);
    request_t r;
    r.kind = kind;
    r.qid = qid[3:0];
    r.tag = tag[15:0];
    r.urgent = urgent;
    r.hold = hold;
    request_q.insert(request_q.size(), r);
  endtask

  function automatic mqde_pkg::kind_t pick_kind();
    int p;
    p = $urandom_range(99);
    if (p < 45) return mqde_pkg::KIND_ADD;
    if (p < 80) return mqde_pkg::KIND_TAKE;
    if (p < 92) return mqde_pkg::KIND_QUERY;
    return KIND_SPARE;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t nxt;
    logic [mqde_pkg::DATA_W-1:0] data;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (request_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
          !(request_q[0].hold && (outstanding != 0 || s_axis_tvalid))) begin
        nxt = request_q[0];
        request_q.delete(0);
        data = '0;
        data[mqde_pkg::QID_LSB +: mqde_pkg::QID_W] = nxt.qid;
        data[mqde_pkg::TAG_LSB +: mqde_pkg::TAG_IN_W] = nxt.tag;
        data[mqde_pkg::URG_BIT] = nxt.urgent;
        s_axis_tdata  <= data;
        s_axis_tuser  <= nxt.kind;
        s_axis_tvalid <= 1'b1;
        sent_n        <= sent_n + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // predicts on each accepted request, checks each accepted response
  always @(posedge clk_i or negedge rst_ni) begin
    request_t  r;
    response_t want;
    int        in_n;
    int        out_n;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      outstanding   <= 0;
    end else begin
      in_n = 0;
      out_n = 0;
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (s_axis_tvalid && s_axis_tready) begin
        r.kind = s_axis_tuser;
        r.qid = s_axis_tdata[mqde_pkg::QID_LSB +: mqde_pkg::QID_W];
        r.tag = s_axis_tdata[mqde_pkg::TAG_LSB +: mqde_pkg::TAG_IN_W];
        r.urgent = s_axis_tdata[mqde_pkg::URG_BIT];
        r.hold = 1'b0;
        predicted_resp_q.insert(predicted_resp_q.size(), deque_apply(r));
        in_n = 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_n = 1;
        if (predicted_resp_q.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          want = predicted_resp_q[0];
          predicted_resp_q.delete(0);
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[mqde_pkg::OTAG_LSB +: 16] !== want.out_tag) begin
            $error("out_tag: expected %h, got %h", want.out_tag,
                   m_axis_tdata[mqde_pkg::OTAG_LSB +: 16]);
            errors++;
          end
          if (m_axis_tdata[mqde_pkg::OURG_BIT] !== want.out_urgent) begin
            $error("out_urgent: expected %0d, got %0d", want.out_urgent,
                   m_axis_tdata[mqde_pkg::OURG_BIT]);
            errors++;
          end
          if (m_axis_tdata[mqde_pkg::HAS_BIT] !== want.has_entries) begin
            $error("has_entries: expected %0d, got %0d", want.has_entries,
                   m_axis_tdata[mqde_pkg::HAS_BIT]);
            errors++;
          end
        end
      end
      outstanding <= outstanding + in_n - out_n;
    end
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    int seg_len;
    int qid;
    int pool[3];
    bit first;

    // directed: never-used queues, both ends of the deque, tag and id extremes
    push_req(mqde_pkg::KIND_TAKE,  0, 16'hffff, 1'b1);
    push_req(mqde_pkg::KIND_QUERY, 15, 16'hffff, 1'b1);
    push_req(KIND_SPARE, 3, 16'h1234, 1'b0);
    push_req(mqde_pkg::KIND_ADD,   0, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_ADD,   0, 16'hffff, 1'b1);
    push_req(mqde_pkg::KIND_ADD,   0, 16'h8001, 1'b1);
    push_req(mqde_pkg::KIND_ADD,   15, 16'ha5a5, 1'b1);
    push_req(mqde_pkg::KIND_ADD,   15, 16'h5a5a, 1'b0);
    push_req(mqde_pkg::KIND_QUERY, 0, 16'h0000, 1'b0);
    push_req(KIND_SPARE, 15, 16'hffff, 1'b1);
    push_req(mqde_pkg::KIND_TAKE,  0, 16'hffff, 1'b1);
    push_req(mqde_pkg::KIND_TAKE,  0, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_TAKE,  0, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_TAKE,  0, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_TAKE,  15, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_QUERY, 15, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_TAKE,  15, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_TAKE,  15, 16'h0000, 1'b0);
    push_req(mqde_pkg::KIND_QUERY, 15, 16'h0000, 1'b0, 1'b1);

    // random: mixed traffic on a few queues, with fill-to-full and drain bursts
    n = 0;
    first = 1'b1;
    while (n < RANDOM_REQS) begin
      if (first || $urandom_range(9) == 0) begin
        first = 1'b0;
        qid = $urandom_range(NUM_Q - 1);
        seg_len = DEPTH + $urandom_range(2, 6);
        for (int i = 0; i < seg_len; i++)
          push_req(mqde_pkg::KIND_ADD, qid, $urandom, $urandom_range(3) == 0);
        push_req(mqde_pkg::KIND_QUERY, qid, $urandom, 1'($urandom_range(1)), 1'b1);
        for (int i = 0; i < DEPTH + 4; i++)
          push_req(($urandom_range(9) == 0) ? pick_kind() : mqde_pkg::KIND_TAKE, qid,
                   $urandom, 1'($urandom_range(1)));
        n += seg_len + DEPTH + 5;
      end else begin
        foreach (pool[i]) pool[i] = $urandom_range(NUM_Q - 1);
        seg_len = $urandom_range(10, 40);
        for (int i = 0; i < seg_len; i++) begin
          qid = ($urandom_range(4) == 0) ? $urandom_range(NUM_Q - 1) : pool[$urandom_range(2)];
          push_req(pick_kind(), qid, $urandom, 1'($urandom_range(1)));
        end
        n += seg_len;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid || outstanding != 0 ||
           predicted_resp_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
